@@ sv/fdef_pkg.sv @@
// Shared constants and types for the forward-difference edge filter.
// No dependencies; imported by the top level and by its checker.
package fdef_pkg;

  // Widths fixed by the interface.
  localparam int CfgW  = 10;
  localparam int PixW  = 16;
  localparam int RowW  = 9;
  localparam int TagW  = 9;
  localparam int CfgIdxW = 1;

  // Largest frame height that the row counter supports.
  localparam int MaxHeight = 512;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CfgW-1:0] ImageWidthRst  = 10'd512;
  localparam logic [CfgW-1:0] ImageHeightRst = 10'd512;

endpackage

@@ sv/forward_difference_edge_filter_top.sv @@
// Top level of the forward-difference edge filter: line store, result
// expansion and output register. Depends on fdef_pkg.
//
// The block takes at most one gray pixel per clock in raster order and keeps
// the previous row in a dual-read line store memory. Each accepted pixel reads
// the line store at its own column and the column to its right and writes
// itself back at its column in the same cycle. The first result that a pixel
// causes is formed from the registered reads and payload and loads into the
// output register once it is free. Rows other than the last sustain one pixel
// per cycle while the output is not stalled. In the last row of a frame taller
// than one row, a pixel away from column 0 causes two results, and the bottom
// right pixel three if the frame is wider than one column. The single output
// register then holds back the next pixel until every result of the current
// one has loaded; output stalls hold it back further. Writing either
// configuration register restarts the frame at row 0, column 0.
module forward_difference_edge_filter_top import fdef_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int PIXEL_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  // Pixel input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PixW-1:0]     pixel_value_i,
  // Result output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PixW-1:0]     edge_value_o,
  output logic [TagW-1:0]     out_row_o,
  output logic [TagW-1:0]     out_col_o,
  output logic                frame_done_o
);

  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CmpW = (ColW + 1 > CfgW + 1) ? ColW + 1 : CfgW + 1;

  typedef enum logic [1:0] {
    ResUp,
    ResLeft,
    ResCorner
  } res_sel_e;

  // Absolute difference of two pixel samples.
  function automatic logic [PIXEL_BITS-1:0] abs_diff(logic [PIXEL_BITS-1:0] a,
                                                     logic [PIXEL_BITS-1:0] b);
    logic [PIXEL_BITS-1:0] r;
    if (a > b) begin
      r = a - b;
    end else begin
      r = b - a;
    end
    return r;
  endfunction

  // Configuration registers and frame position.
  logic [CfgW-1:0]        width_q, height_q;
  logic [ColW-1:0]        col_q, col_d;
  logic [RowW-1:0]        row_q, row_d;
  logic [PIXEL_BITS-1:0]  left_q;

  // Line store and its registered read data.
  logic [PIXEL_BITS-1:0]  line_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0]  rd_here_q, rd_right_q;

  // Item waiting for its results.
  logic [2:0]             pend_q, pend_d, pend_next;
  logic [PIXEL_BITS-1:0]  s1_px_q, s1_left_q;
  logic [RowW-1:0]        s1_row_q;
  logic [ColW-1:0]        s1_col_q;
  logic                   s1_last_col_q;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  logic [PixW-1:0]        edge_q;
  logic [TagW-1:0]        row_tag_q, col_tag_q;
  logic                   done_q;

  logic [CmpW-1:0]        w_eff;
  logic [CfgW-1:0]        h_eff;
  logic                   last_col, last_row;
  logic                   in_acc, out_load;
  logic [PIXEL_BITS-1:0]  px;
  res_sel_e               sel;
  logic [2:0]             sel_mask;
  logic [PIXEL_BITS-1:0]  op_p, op_right, op_below;
  logic [PIXEL_BITS:0]    grad_sum;
  logic [TagW-1:0]        row_tag_d, col_tag_d;

  // Effective frame size: zero counts as one, oversize is clipped.
  always_comb begin
    if (width_q == '0) begin
      w_eff = CmpW'(1);
    end else if (CmpW'(width_q) > CmpW'(MAX_WIDTH)) begin
      w_eff = CmpW'(MAX_WIDTH);
    end else begin
      w_eff = CmpW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = CfgW'(1);
    end else if (height_q > CfgW'(MaxHeight)) begin
      h_eff = CfgW'(MaxHeight);
    end else begin
      h_eff = height_q;
    end
  end

  assign last_col = (CmpW'(col_q) + CmpW'(1)) >= w_eff;
  assign last_row = (CfgW'(row_q) + CfgW'(1)) >= h_eff;
  assign px       = pixel_value_i[PIXEL_BITS-1:0];
  assign in_acc   = in_valid_i && in_ready_o;

  // Next frame position; a configuration write restarts the frame.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  // Pick the oldest pending result of the waiting item.
  always_comb begin
    priority if (pend_q[0]) begin
      sel      = ResUp;
      sel_mask = 3'b001;
    end else if (pend_q[1]) begin
      sel      = ResLeft;
      sel_mask = 3'b010;
    end else begin
      sel      = ResCorner;
      sel_mask = 3'b100;
    end
  end

  // Operands and tags of the selected result.
  always_comb begin
    unique case (sel)
      ResUp: begin
        op_p      = rd_here_q;
        op_right  = s1_last_col_q ? rd_here_q : rd_right_q;
        op_below  = s1_px_q;
        row_tag_d = TagW'(s1_row_q - RowW'(1));
        col_tag_d = TagW'(s1_col_q);
      end
      ResLeft: begin
        op_p      = s1_left_q;
        op_right  = s1_px_q;
        op_below  = s1_left_q;
        row_tag_d = TagW'(s1_row_q);
        col_tag_d = TagW'(s1_col_q - ColW'(1));
      end
      ResCorner: begin
        op_p      = s1_px_q;
        op_right  = s1_px_q;
        op_below  = s1_px_q;
        row_tag_d = TagW'(s1_row_q);
        col_tag_d = TagW'(s1_col_q);
      end
      default: begin
        op_p      = s1_px_q;
        op_right  = s1_px_q;
        op_below  = s1_px_q;
        row_tag_d = TagW'(s1_row_q);
        col_tag_d = TagW'(s1_col_q);
      end
    endcase
    grad_sum = {1'b0, abs_diff(op_below, op_p)} + {1'b0, abs_diff(op_right, op_p)};
  end

  // Handshake: the waiting item frees its slot once its last result loads.
  assign out_load  = (pend_q != '0) && (!out_valid_q || out_ready_i);
  assign pend_next = out_load ? (pend_q & ~sel_mask) : pend_q;
  assign in_ready_o = (pend_next == '0);

  always_comb begin
    pend_d = pend_next;
    if (in_acc) begin
      pend_d = {last_row && last_col, last_row && (col_q != '0), row_q != '0};
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= ImageWidthRst;
      height_q    <= ImageHeightRst;
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegImageWidth:  width_q  <= cfg_data_i;
          RegImageHeight: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      col_q       <= col_d;
      row_q       <= row_d;
      if (in_acc) begin
        left_q <= px;
      end
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Line store: read here and to the right, write the new pixel back.
  // Reads return the contents from before this cycle's write.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_here_q       <= line_mem[col_q];
      rd_right_q      <= line_mem[col_q + ColW'(1)];
      line_mem[col_q] <= px;
    end
  end

  // Payload of the waiting item.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q       <= px;
      s1_left_q     <= left_q;
      s1_row_q      <= row_q;
      s1_col_q      <= col_q;
      s1_last_col_q <= last_col;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      edge_q    <= PixW'(grad_sum[PIXEL_BITS:1]);
      row_tag_q <= row_tag_d;
      col_tag_q <= col_tag_d;
      done_q    <= (sel == ResCorner);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign edge_value_o = edge_q;
  assign out_row_o    = row_tag_q;
  assign out_col_o    = col_tag_q;
  assign frame_done_o = done_q;

endmodule

@@ sv/fdef_checker.sv @@
// Port-level checker for the forward-difference edge filter and its bind.
// Depends on fdef_pkg and on forward_difference_edge_filter_top.
module fdef_checker import fdef_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [PixW-1:0]    edge_value_o,
  input logic [TagW-1:0]    out_row_o,
  input logic [TagW-1:0]    out_col_o,
  input logic               frame_done_o
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(edge_value_o) &&
      $stable(out_row_o) && $stable(out_col_o) && $stable(frame_done_o))
    else $error("stalled result changed");

  // The bottom right pixel has no neighbours, so its gradient is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> edge_value_o == '0)
    else $error("frame end result with non-zero gradient");

  // Input is held back only while results are pending, so one appears next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> out_valid_o)
    else $error("input stalled without a pending result");

  // No result is valid when reset is released, before any input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid straight after reset");

endmodule

bind forward_difference_edge_filter_top fdef_checker u_fdef_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .edge_value_o (edge_value_o),
  .out_row_o    (out_row_o),
  .out_col_o    (out_col_o),
  .frame_done_o (frame_done_o)
);

@@ sim/tb_forward_difference_edge_filter_top.sv @@
// Self-checking testbench for forward_difference_edge_filter_top.
// Depends on fdef_pkg and the top level. Every result transaction is checked against the
// value, row, column and flag from a built-in gradient predictor or the directed table.
module tb_forward_difference_edge_filter_top import fdef_pkg::*;;

  // Line store depth of the block as built, and run timing.
  localparam int LineDepth  = 512;
  localparam int SettleCyc  = 8;
  localparam int RecvHold   = 200;
  localparam int RandTarget = 220;
  localparam int FrameTall  = 64;

  // One expected result transaction.
  typedef struct packed {
    logic [PixW-1:0] mag;
    logic [TagW-1:0] row;
    logic [TagW-1:0] col;
    logic            done;
  } edge_res_t;

  // One row of the directed stimulus table.
  typedef enum logic [1:0] {RowCfgWidth, RowCfgHeight, RowPixel} dir_kind_e;
  typedef struct {
    dir_kind_e       kind;
    logic [PixW-1:0] val;
    bit              typed;
    edge_res_t       res;
  } dir_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i  = '0;
  logic [CfgW-1:0]   cfg_data_i    = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [PixW-1:0]   pixel_value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [PixW-1:0]   edge_value_o;
  logic [TagW-1:0]   out_row_o;
  logic [TagW-1:0]   out_col_o;
  logic              frame_done_o;

  // Predictor state: configuration, line store, left pixel and raster position.
  logic [CfgW-1:0]   img_width  = ImageWidthRst;
  logic [CfgW-1:0]   img_height = ImageHeightRst;
  logic [PixW-1:0]   line_mem [LineDepth];
  logic [PixW-1:0]   left_px  = '0;
  int unsigned       cur_row  = 0;
  int unsigned       cur_col  = 0;
  edge_res_t         fresh_res [3];

  edge_res_t         expected_edges [$];
  dir_row_t          dir_table [$];
  logic [PixW-1:0]   last_px = '0;
  int                err_count = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                hold_token = 0;
  int                hold_seen = 0;
  int                hold_left = 0;

  forward_difference_edge_filter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .edge_value_o  (edge_value_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .frame_done_o  (frame_done_o)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Out-of-range sizes are clamped: zero counts as one, anything above the cap as the cap.
  function automatic int unsigned eff_dim(input logic [CfgW-1:0] v, input int unsigned cap);
    if (v == '0) return 1;
    if (int'(v) > cap) return cap;
    return int'(v);
  endfunction

  function automatic logic [PixW-1:0] half_grad(input int unsigned p, input int unsigned right,
                                                input int unsigned below);
    int unsigned dr, db;
    dr = (right > p) ? right - p : p - right;
    db = (below > p) ? below - p : p - below;
    return PixW'((dr + db) / 2);
  endfunction

  function automatic edge_res_t make_res(input logic [PixW-1:0] mag, input int unsigned row,
                                         input int unsigned col, input logic done);
    edge_res_t res;
    res.mag  = mag;
    res.row  = TagW'(row);
    res.col  = TagW'(col);
    res.done = done;
    return res;
  endfunction

  // Works out the results caused by one pixel and advances the raster position.
  function automatic int predict_gradient(input logic [PixW-1:0] px);
    int unsigned w, h, r, c, above, above_right;
    bit last_col, last_row;
    int n;
    w = eff_dim(img_width, LineDepth);
    h = eff_dim(img_height, MaxHeight);
    r = cur_row;
    c = cur_col;
    n = 0;
    if (c >= LineDepth) c = LineDepth - 1;
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= h);
    // Pixel above is complete now that its lower neighbour has arrived.
    if (r > 0) begin
      above       = line_mem[c];
      above_right = last_col ? above : line_mem[c + 1];
      fresh_res[n] = make_res(half_grad(above, above_right, px), r - 1, c, 1'b0);
      n++;
    end
    // In the bottom row the left pixel is complete, and the corner closes the frame.
    if (last_row) begin
      if (c > 0) begin
        fresh_res[n] = make_res(half_grad(left_px, px, left_px), r, c - 1, 1'b0);
        n++;
      end
      if (last_col) begin
        fresh_res[n] = make_res('0, r, c, 1'b1);
        n++;
      end
    end
    line_mem[c] = px;
    left_px     = px;
    if (last_col) begin
      cur_col = 0;
      cur_row = last_row ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
    end
    return n;
  endfunction

  function automatic void add_row(input dir_kind_e kind, input logic [PixW-1:0] val,
                                  input bit typed, input edge_res_t res);
    dir_row_t entry;
    entry.kind  = kind;
    entry.val   = val;
    entry.typed = typed;
    entry.res   = res;
    dir_table.push_back(entry);
  endfunction

  // Random pixels lean towards extremes and repeats so that zero differences occur.
  function automatic logic [PixW-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return last_px;
      3: return last_px + PixW'($urandom_range(0, 3));
      default: return PixW'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Offers one pixel transaction, with random gaps before it, and records its results.
  task automatic send_pixel(input logic [PixW-1:0] px, input bit typed,
                            input edge_res_t typed_res);
    int n;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_value_i <= px;
    do @(posedge clk_i); while (!in_ready_o);
    last_px = px;
    n = predict_gradient(px);
    if (typed) expected_edges.push_back(typed_res);
    else for (int k = 0; k < n; k++) expected_edges.push_back(fresh_res[k]);
  endtask

  // Waits for every expected result, then lets the pipeline settle.
  task automatic wait_idle();
    do @(posedge clk_i); while (expected_edges.size() != 0);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // A register write restarts the frame at row 0, column 0.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegImageWidth) img_width = data;
    else img_height = data;
    cur_row = 0;
    cur_col = 0;
    @(posedge clk_i);
  endtask

  // Which: 0 writes both registers, 1 the width only, 2 the height only.
  task automatic configure(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h,
                           input int which);
    in_valid_i <= 1'b0;
    wait_idle();
    if (which != 2) write_reg(RegImageWidth, w);
    if (which != 1) write_reg(RegImageHeight, h);
  endtask

  // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen   <= hold_token;
      hold_left   <= RecvHold;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result checker: each accepted transaction against the oldest expectation.
  always @(posedge clk_i) begin
    edge_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_edges.size() == 0) begin
        report_mismatch("unexpected result (row)", out_row_o, 0);
      end else begin
        want = expected_edges.pop_front();
        if (edge_value_o !== want.mag) report_mismatch("edge_value", edge_value_o, want.mag);
        if (out_row_o !== want.row) report_mismatch("out_row", out_row_o, want.row);
        if (out_col_o !== want.col) report_mismatch("out_col", out_col_o, want.col);
        if (frame_done_o !== want.done) report_mismatch("frame_done", frame_done_o, want.done);
      end
    end
  end

  // Overall time limit.
  initial begin
    #5000000;
    $display("** forward_difference_edge_filter_top: FAILED **");
    $finish;
  end

  // Main stimulus.
  initial begin
    dir_row_t step;
    logic [CfgW-1:0] w, h;
    int n, done_items, phase;

    // Single-pixel frames: every pixel is its own corner, so the result is fixed.
    add_row(RowCfgWidth, 16'd1, 1'b0, '0);
    add_row(RowCfgHeight, 16'd1, 1'b0, '0);
    add_row(RowPixel, 16'hFFFF, 1'b1, make_res('0, 0, 0, 1'b1));
    add_row(RowPixel, 16'h0000, 1'b1, make_res('0, 0, 0, 1'b1));
    // Zero sizes behave as one.
    add_row(RowCfgWidth, 16'd0, 1'b0, '0);
    add_row(RowCfgHeight, 16'd0, 1'b0, '0);
    add_row(RowPixel, 16'h1234, 1'b1, make_res('0, 0, 0, 1'b1));
    // 2x2 frame with full-scale differences in both directions.
    add_row(RowCfgWidth, 16'd2, 1'b0, '0);
    add_row(RowCfgHeight, 16'd2, 1'b0, '0);
    add_row(RowPixel, 16'h0000, 1'b0, '0);
    add_row(RowPixel, 16'hFFFF, 1'b0, '0);
    add_row(RowPixel, 16'hFFFF, 1'b0, '0);
    add_row(RowPixel, 16'h0000, 1'b0, '0);
    // Single-row frame: every result comes from the bottom row path.
    add_row(RowCfgWidth, 16'd3, 1'b0, '0);
    add_row(RowCfgHeight, 16'd1, 1'b0, '0);
    add_row(RowPixel, 16'h8000, 1'b0, '0);
    add_row(RowPixel, 16'h0001, 1'b0, '0);
    add_row(RowPixel, 16'h7FFF, 1'b0, '0);
    // Oversized registers, left after a partial first row.
    add_row(RowCfgWidth, 16'h03FF, 1'b0, '0);
    add_row(RowCfgHeight, 16'h03FF, 1'b0, '0);
    add_row(RowPixel, 16'hAAAA, 1'b0, '0);
    add_row(RowPixel, 16'h5555, 1'b0, '0);
    // Partial 2x3 frame with equal neighbours, then a restart by a height write.
    add_row(RowCfgWidth, 16'd2, 1'b0, '0);
    add_row(RowCfgHeight, 16'd3, 1'b0, '0);
    add_row(RowPixel, 16'd5, 1'b0, '0);
    add_row(RowPixel, 16'd5, 1'b0, '0);
    add_row(RowPixel, 16'd5, 1'b0, '0);
    add_row(RowPixel, 16'd9, 1'b0, '0);
    add_row(RowPixel, 16'd7, 1'b0, '0);
    add_row(RowCfgHeight, 16'd3, 1'b0, '0);
    for (int i = 1; i <= 6; i++) add_row(RowPixel, PixW'(i), 1'b0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct <= 30;
    recv_idle_pct <= 67;
    @(posedge clk_i);

    // Directed table.
    foreach (dir_table[i]) begin
      step = dir_table[i];
      if (step.kind == RowPixel) begin
        send_pixel(step.val, step.typed, step.res);
      end else begin
        in_valid_i <= 1'b0;
        wait_idle();
        write_reg((step.kind == RowCfgWidth) ? RegImageWidth : RegImageHeight,
                  CfgW'(step.val));
      end
    end

    // Random frames under three idling regimes.
    done_items = 0;
    phase = 0;
    while (done_items < RandTarget) begin
      if (done_items >= 2 * RandTarget / 3) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end else if (done_items >= RandTarget / 3) begin
        send_idle_pct <= 67;
        recv_idle_pct <= 30;
      end
      if (phase == 2) begin
        // Long receiver hold-off while the sender keeps offering pixels.
        configure(CfgW'(6), CfgW'(2), 0);
        hold_token <= hold_token + 1;
        n = 36;
      end else begin
        case ($urandom_range(0, 9))
          0: begin w = '1; h = CfgW'(1); end
          1: begin w = '0; h = CfgW'($urandom_range(0, 4)); end
          2: begin w = CfgW'($urandom_range(1, 8)); h = '0; end
          3: begin w = CfgW'(1); h = CfgW'($urandom_range(513, 1023)); end
          default: begin
            w = CfgW'($urandom_range(1, 8));
            h = CfgW'($urandom_range(1, 5));
          end
        endcase
        configure(w, h, (phase == 0) ? 0 : $urandom_range(0, 2));
        n = eff_dim(img_width, LineDepth) * eff_dim(img_height, MaxHeight)
            * $urandom_range(1, 3) + $urandom_range(0, 3);
        if (n > 64) n = $urandom_range(20, 64);
      end
      for (int i = 0; i < n; i++) send_pixel(rand_pixel(), 1'b0, '0);
      done_items += n;
      phase++;
    end

    // The top of a frame at the clipped height, with a pause until the output drains.
    configure(CfgW'(1), CfgW'(600), 0);
    for (int i = 0; i < FrameTall; i++) begin
      if (i == FrameTall / 2) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (expected_edges.size() != 0);
      end
      send_pixel(rand_pixel(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    wait_idle();
    if (err_count == 0) begin
      $display("** forward_difference_edge_filter_top: PASSED **");
    end else begin
      $display("** forward_difference_edge_filter_top: FAILED **");
    end
    $finish;
  end

endmodule
